// File: hdl/tspat_pkg.sv
`timescale 1ns / 1ps

package tspat_pkg;

   localparam int PACKET_BYTES = 188;
   localparam int POS_W        = $clog2(PACKET_BYTES);
   localparam int PID_W        = 13;
   localparam int LEN_W        = 12;
   localparam int WIN_W        = 32;

   localparam logic [POS_W-1:0] LAST_POS       = POS_W'(PACKET_BYTES - 1);
   localparam logic [POS_W-1:0] POS_PAT_CHECK  = POS_W'(2);
   localparam logic [POS_W-1:0] POS_SEC_START  = POS_W'(5);
   localparam logic [POS_W-1:0] POS_LEN_HI     = POS_W'(6);
   localparam logic [POS_W-1:0] POS_LEN_LO     = POS_W'(7);
   localparam logic [POS_W-1:0] POS_PREFIX_END = POS_W'(12);
   localparam logic [POS_W-1:0] POS_ENTRY      = POS_W'(13);
   localparam logic [POS_W-1:0] POS_ENTRY_END  = POS_W'(16);
   localparam logic [POS_W-1:0] POS_CRC        = POS_W'(17);
   localparam logic [POS_W-1:0] POS_CRC_END    = POS_W'(20);
   localparam logic [POS_W-1:0] POS_FILL       = POS_W'(21);

   localparam logic [7:0]  SYNC_BYTE   = 8'h47;
   localparam logic [7:0]  PAT_BYTE1   = 8'h40;
   localparam logic [7:0]  PAT_BYTE2   = 8'h00;
   localparam logic [7:0]  FILL_BYTE   = 8'hFF;
   localparam logic [7:0]  HI_NIBBLE   = 8'hF0;
   localparam logic [7:0]  REWRITE_LEN = 8'(21 - 8);
   localparam logic [4:0]  PID_HI_MASK = 5'h1F;
   localparam logic [31:0] CRC_POLY    = 32'h04C1_1DB7;
   localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
   localparam logic [PID_W-1:0] PID_RESET = {PID_W{1'b1}};

   typedef struct packed {
      logic        rewrite;
      logic [31:0] entry;
      logic [31:0] crc;
   } emit_type;

   typedef struct packed {
      logic       primed;
      logic       last;
      logic       ovr;
      logic       mask;
      logic [7:0] ovr_byte;
   } slot_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {b, 24'h0};
      for (int k = 0; k < 8; k++) begin
         if (c[31]) begin
            c = {c[30:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[30:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// File: hdl/tspat_ram.sv
`timescale 1ns / 1ps

module tspat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 188
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read and write of one address in a cycle returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/tspat_scan.sv
`timescale 1ns / 1ps

module tspat_scan (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [tspat_pkg::POS_W-1:0] pos,
   input  logic [7:0]                  data,
   input  logic [tspat_pkg::PID_W-1:0] pmt_pid,
   output tspat_pkg::emit_type         emit
);
   import tspat_pkg::*;

   logic [23:0]      prev_ff, prev_in;
   logic             is_pat_ff, is_pat_in;
   logic [LEN_W-1:0] sec_len_ff, sec_len_in;
   logic             found_ff, found_in;
   logic [31:0]      kept_entry_ff, kept_entry_in;
   logic [31:0]      kept_crc_ff, kept_crc_in;
   logic [31:0]      prefix_crc_ff, prefix_crc_in;
   logic [31:0]      cand_crc_ff, cand_crc_in;
   emit_type         emit_ff, emit_in;

   logic [WIN_W-1:0] window;
   logic [31:0]      crc_src;
   logic [7:0]       crc_data;
   logic [31:0]      crc_out;
   logic             in_prefix;
   logic             group_start;
   logic             check;
   logic             match;

   assign window      = {prev_ff, data};
   assign in_prefix   = (pos >= POS_SEC_START) && (pos <= POS_PREFIX_END);
   assign group_start = (pos >= POS_ENTRY) && (pos[1:0] == POS_ENTRY[1:0]);
   assign check       = (pos >= POS_ENTRY_END) && (pos[1:0] == POS_ENTRY_END[1:0]) &&
                        !found_ff &&
                        ({(PID_W - POS_W)'(0), pos} <= ({1'b0, sec_len_ff} + PID_W'(3)));
   assign match       = (window[12:8] == (pmt_pid[12:8] & PID_HI_MASK)) &&
                        (window[7:0] == pmt_pid[7:0]);

   // one shared byte step: section prefix first, then each candidate entry on it
   always_comb begin
      if (pos == POS_SEC_START) begin
         crc_src = CRC_INIT;
      end else if (in_prefix || group_start) begin
         crc_src = prefix_crc_ff;
      end else begin
         crc_src = cand_crc_ff;
      end
      if (pos == POS_LEN_HI) begin
         crc_data = data & HI_NIBBLE;
      end else if (pos == POS_LEN_LO) begin
         crc_data = REWRITE_LEN;
      end else begin
         crc_data = data;
      end
      crc_out = crc_byte(crc_src, crc_data);
   end

   always_comb begin
      prev_in       = prev_ff;
      is_pat_in     = is_pat_ff;
      sec_len_in    = sec_len_ff;
      found_in      = found_ff;
      kept_entry_in = kept_entry_ff;
      kept_crc_in   = kept_crc_ff;
      prefix_crc_in = prefix_crc_ff;
      cand_crc_in   = cand_crc_ff;
      emit_in       = emit_ff;
      if (accept) begin
         prev_in = window[23:0];
         if (in_prefix) begin
            prefix_crc_in = crc_out;
         end
         if (pos >= POS_ENTRY) begin
            cand_crc_in = crc_out;
         end
         if (pos == '0) begin
            is_pat_in  = 1'b0;
            found_in   = 1'b0;
            sec_len_in = '0;
         end
         if (pos == POS_PAT_CHECK) begin
            is_pat_in = (window[23:0] == {SYNC_BYTE, PAT_BYTE1, PAT_BYTE2});
         end
         if (pos == POS_LEN_LO) begin
            sec_len_in = window[LEN_W-1:0];
         end
         if (check && match) begin
            found_in      = 1'b1;
            kept_entry_in = window;
            kept_crc_in   = crc_out;
         end
         if (pos == LAST_POS) begin
            emit_in.rewrite = is_pat_ff && found_in;
            if (is_pat_ff && found_in) begin
               emit_in.entry = kept_entry_in;
               emit_in.crc   = kept_crc_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff         <= '0;
         is_pat_ff       <= 1'b0;
         sec_len_ff      <= '0;
         found_ff        <= 1'b0;
         emit_ff.rewrite <= 1'b0;
      end else begin
         prev_ff         <= prev_in;
         is_pat_ff       <= is_pat_in;
         sec_len_ff      <= sec_len_in;
         found_ff        <= found_in;
         emit_ff.rewrite <= emit_in.rewrite;
      end
      kept_entry_ff <= kept_entry_in;
      kept_crc_ff   <= kept_crc_in;
      prefix_crc_ff <= prefix_crc_in;
      cand_crc_ff   <= cand_crc_in;
      emit_ff.entry <= emit_in.entry;
      emit_ff.crc   <= emit_in.crc;
   end

   assign emit = emit_ff;

`ifndef NO_ASSERTIONS
   a_found_needs_check: assert property (@(posedge clock) disable iff (reset)
      !found_ff && found_in |-> accept && check && match)
      else $error("entry latched outside a checked slot");
   a_found_cleared: assert property (@(posedge clock) disable iff (reset)
      accept && pos == '0 |=> !found_ff && !is_pat_ff)
      else $error("packet state not cleared at packet start");
   a_emit_only_close: assert property (@(posedge clock) disable iff (reset)
      !(accept && pos == LAST_POS) |=> $stable(emit_ff.rewrite))
      else $error("rewrite flag changed away from packet close");
`endif

endmodule

// File: hdl/ts_pat_single_program_rewriter.sv
// Single-program PAT rewriter for an aligned MPEG-2 transport stream.
// req: one stream byte per transfer in req_tdata; the byte count is kept
//   internally, so the stream must start on a packet boundary after reset.
// rsp: one result per input transfer. rsp_tdata is the byte at the same
//   position of the previous packet; rsp_tuser is 1 once a whole packet has
//   been stored (during the first packet tdata and tlast are 0); rsp_tlast
//   marks byte 187. A PAT holding an entry for the PMT PID comes out cut down
//   to that single entry with a new section length, CRC and 0xFF fill.
// csr: write of the 13-bit PMT PID (reset 8191), only while the block is idle.
// Throughput: one byte per cycle while rsp is not stalled. Each byte reads and
//   writes the packet memory at the same address in its transfer cycle
//   (read-first port); the memory read data and the stage flags are registered,
//   then the result is registered in the output register that drives rsp.
// A packet is only given out while the next one is fed: the last packet
//   stays inside until more bytes arrive.
// Reset clears the byte count, the PAT state and the output valid; the
//   packet memory is not cleared, no clearing pass is needed.
// When rsp stalls, the output register and the memory stage hold and
//   req_tready drops once both are full; nothing is lost or repeated.
`timescale 1ns / 1ps

module ts_pat_single_program_rewriter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] data_byte
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,   // [7:0] out_byte
   output logic                        rsp_tuser,   // [0] out_valid
   output logic                        rsp_tlast,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [tspat_pkg::PID_W-1:0] csr_data
);
   import tspat_pkg::*;

   logic [PID_W-1:0] pmt_pid_ff, pmt_pid_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             primed_ff, primed_in;
   logic             s1_valid_ff, s1_valid_in;
   slot_type         s1_ff, s1_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]       rsp_tdata_ff, rsp_tdata_in;
   logic             rsp_tuser_ff, rsp_tuser_in;
   logic             rsp_tlast_ff, rsp_tlast_in;

   logic             advance;
   logic             accept;
   logic [7:0]       rd_data;
   emit_type         emit;
   logic [1:0]       byte_sel;
   logic [7:0]       s1_byte;

   function automatic logic [7:0] pick_byte(input logic [31:0] w, input logic [1:0] sel);
      logic [7:0] r;
      unique case (sel)
         2'd0:    r = w[31:24];
         2'd1:    r = w[23:16];
         2'd2:    r = w[15:8];
         default: r = w[7:0];
      endcase
      return r;
   endfunction

   assign advance    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign byte_sel   = pos_ff[1:0] - 2'd1;

   tspat_ram #(
      .WIDTH (8),
      .DEPTH (PACKET_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (pos_ff),
      .wr_data (req_tdata),
      .rd_en   (accept),
      .rd_addr (pos_ff),
      .rd_data (rd_data)
   );

   tspat_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .pos     (pos_ff),
      .data    (req_tdata),
      .pmt_pid (pmt_pid_ff),
      .emit    (emit)
   );

   // rewrite decision taken at transfer time, against the packet now going out
   always_comb begin
      s1_in          = s1_ff;
      s1_in.primed   = primed_ff;
      s1_in.last     = (pos_ff == LAST_POS);
      s1_in.mask     = emit.rewrite && (pos_ff == POS_LEN_HI);
      s1_in.ovr      = 1'b0;
      s1_in.ovr_byte = FILL_BYTE;
      if (emit.rewrite) begin
         priority if (pos_ff == POS_LEN_LO) begin
            s1_in.ovr      = 1'b1;
            s1_in.ovr_byte = REWRITE_LEN;
         end else if (pos_ff >= POS_ENTRY && pos_ff <= POS_ENTRY_END) begin
            s1_in.ovr      = 1'b1;
            s1_in.ovr_byte = pick_byte(emit.entry, byte_sel);
         end else if (pos_ff >= POS_CRC && pos_ff <= POS_CRC_END) begin
            s1_in.ovr      = 1'b1;
            s1_in.ovr_byte = pick_byte(emit.crc, byte_sel);
         end else if (pos_ff >= POS_FILL) begin
            s1_in.ovr      = 1'b1;
            s1_in.ovr_byte = FILL_BYTE;
         end
      end
   end

   always_comb begin
      priority if (!s1_ff.primed) begin
         s1_byte = 8'h00;
      end else if (s1_ff.ovr) begin
         s1_byte = s1_ff.ovr_byte;
      end else if (s1_ff.mask) begin
         s1_byte = rd_data & HI_NIBBLE;
      end else begin
         s1_byte = rd_data;
      end
   end

   always_comb begin
      pmt_pid_in    = csr_valid ? csr_data : pmt_pid_ff;
      pos_in        = pos_ff;
      primed_in     = primed_ff;
      s1_valid_in   = s1_valid_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      if (accept) begin
         if (pos_ff == LAST_POS) begin
            pos_in    = '0;
            primed_in = 1'b1;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
      if (advance) begin
         rsp_tvalid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            rsp_tdata_in = s1_byte;
            rsp_tuser_in = s1_ff.primed;
            rsp_tlast_in = s1_ff.primed && s1_ff.last;
         end
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pmt_pid_ff    <= PID_RESET;
         pos_ff        <= '0;
         primed_ff     <= 1'b0;
         s1_valid_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         pmt_pid_ff    <= pmt_pid_in;
         pos_ff        <= pos_in;
         primed_ff     <= primed_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      if (accept) begin
         s1_ff <= s1_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

`ifndef NO_ASSERTIONS
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_tvalid_ff && !rsp_tready |-> !req_tready)
      else $error("transfer taken while both stages are full");
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LAST_POS)
      else $error("byte position beyond the packet");
   a_pos_wraps: assert property (@(posedge clock) disable iff (reset)
      accept && pos_ff == LAST_POS |=> pos_ff == '0 && primed_ff)
      else $error("byte position did not wrap at packet end");
   a_last_needs_primed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_tlast_ff |-> rsp_tuser_ff)
      else $error("packet end marked before a packet was stored");
`endif

endmodule
